### hw/rtl/scmp_pkg.sv
// Shared types, constants and saturating helpers for the S-curve motion profile unit.
package scmp_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [31:0] JERK_RST  = 32'd131072000;
  localparam logic [31:0] ACCEL_RST = 32'd32768000;
  localparam logic [31:0] VLIM_RST  = 32'd4096000;

  // Configuration register indexes
  localparam logic [1:0] CFG_JERK  = 2'd0;
  localparam logic [1:0] CFG_ACCEL = 2'd1;
  localparam logic [1:0] CFG_VLIM  = 2'd2;

  // Request types
  localparam logic REQ_PLAN   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Profile phases
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Divide the jerk position term by six: (q * JP_RECIP) >> JP_SHIFT equals q / 6
  // for every 32-bit q, since JP_RECIP is 2^34 / 6 rounded up
  localparam logic [31:0] JP_RECIP = 32'hAAAA_AAAB;
  localparam int          JP_SHIFT = 34;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] move_distance;
    logic        [31:0] target_velocity;
    logic        [31:0] sample_time;
  } in_word_t;

  typedef struct packed {
    logic [31:0] velocity;
    logic [31:0] position;
    logic [1:0]  phase;
    logic [31:0] total_time;
    logic [31:0] peak_velocity;
  } out_word_t;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    return (x[63:32] != 32'd0) ? QMAX : x[31:0];
  endfunction

  function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? QMAX : s[31:0];
  endfunction

  function automatic logic [31:0] qsub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

### hw/rtl/scmp_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module scmp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import scmp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic        zero_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] trial;
  logic        fits;
  logic [31:0] rem_nxt;

  // Shift in the next dividend bit and try the subtract
  assign trial   = {rem_r, acc_r[63]};
  assign fits    = trial >= {1'b0, den_r};
  assign rem_nxt = fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        rem_r  <= 32'd0;
        acc_r  <= num;
        den_r  <= den;
        zero_r <= (den == 32'd0);
      end else if (busy_r) begin
        acc_r <= {acc_r[62:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Saturate the quotient, and a zero divisor
  assign done = done_r;
  assign quo  = zero_r ? QMAX : sat32(acc_r);

endmodule

### hw/rtl/scmp_sqrt.sv
// Bit-pair integer square root of a 64-bit value, one root bit per cycle.
module scmp_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);
  import scmp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  k_r;
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bitv;
  logic [63:0] sum;
  logic        ge;

  assign bitv = 64'(1) << {k_r, 1'b0};
  assign sum  = res_r + bitv;
  assign ge   = n_r >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 5'd31;
        n_r    <= n;
        res_r  <= 64'd0;
      end else if (busy_r) begin
        // Take one root bit
        if (ge) begin
          n_r   <= n_r - sum;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        k_r <= k_r - 5'd1;
        if (k_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

### hw/rtl/scurve_motion_profile_unit.sv
// Jerk-limited S-curve motion profile in unsigned fixed point. A plan word stores a new profile
// (ramp time, ramp and cruise distances, cruise time, total time); a sample word evaluates the
// stored profile at a time and returns velocity, position and phase. One word is worked at a
// time under a sequencer that shares one 32x32 multiplier, a radix-2 divider and a bit-pair
// square root. A plan runs two ramp-time passes and the cruise-time division, and when the move
// is too short to cruise also a cube root, which uses the multiplier for each of its 32 bits.
// A sample uses the multiplier for the jerk terms, with the division by six done as a
// reciprocal multiply. The input is stalled while a word is in progress; a finished result
// waits in the output register while the next word is taken.
module scurve_motion_profile_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scmp_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scmp_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import scmp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CAP  = 5'd1;
  localparam logic [4:0] S_CAPW = 5'd2;
  localparam logic [4:0] S_RTW  = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_VT   = 5'd5;
  localparam logic [4:0] S_VT2  = 5'd6;
  localparam logic [4:0] S_DD2  = 5'd7;
  localparam logic [4:0] S_W    = 5'd8;
  localparam logic [4:0] S_C1   = 5'd9;
  localparam logic [4:0] S_C2   = 5'd10;
  localparam logic [4:0] S_C3   = 5'd11;
  localparam logic [4:0] S_C4   = 5'd12;
  localparam logic [4:0] S_J1   = 5'd13;
  localparam logic [4:0] S_J2   = 5'd14;
  localparam logic [4:0] S_J3   = 5'd15;
  localparam logic [4:0] S_J4   = 5'd16;
  localparam logic [4:0] S_J5   = 5'd17;
  localparam logic [4:0] S_CT   = 5'd18;
  localparam logic [4:0] S_DUR  = 5'd19;
  localparam logic [4:0] S_SMP  = 5'd20;
  localparam logic [4:0] S_P1   = 5'd21;
  localparam logic [4:0] S_P2   = 5'd22;
  localparam logic [4:0] S_P2B  = 5'd23;
  localparam logic [4:0] S_OUT  = 5'd24;

  // Caller of the jerk term routine
  localparam logic [1:0] CTX_PLAN = 2'd0;
  localparam logic [1:0] CTX_PH0  = 2'd1;
  localparam logic [1:0] CTX_PH2  = 2'd2;

  // Configuration
  logic [31:0] jerk_r, accel_r, vlim_r;

  // Stored profile
  logic [31:0] len_r, vc_r, rt_r, rd_r, cd_r, ct_r, dur_r;

  // Working registers
  logic [4:0]  st_r;
  logic        pass_r;
  logic [1:0]  ctx_r;
  logic [31:0] d_r, v_r, s_r, cap_r, t_r, x_r, r_r, q2_r, jp_r, c2hi_r;
  logic [63:0] lo_r;
  logic [4:0]  b_r;
  logic [63:0] prod_r;
  logic [31:0] ovel_r, opos_r;
  logic [1:0]  oph_r;
  logic        out_valid_r;
  out_word_t   out_data_r;

  // Shared units
  logic        div_start, div_done;
  logic [63:0] div_num;
  logic [31:0] div_den, div_quo;
  logic        sq_start, sq_done;
  logic [63:0] sq_n;
  logic [31:0] sq_root;
  logic [31:0] mul_a, mul_b;

  logic [31:0] qm, cand, t_min, ce, jp, cd, abs_d, rn;
  logic [95:0] c3;
  logic        fits, in_acc, out_free, out_load;

  scmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  scmp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n     (sq_n),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (st_r == S_OUT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Common terms
  assign qm    = sat32(prod_r >> FRAC_BITS);
  assign cand  = r_r | (32'(1) << b_r);
  assign t_min = (cap_r < sq_root) ? cap_r : sq_root;
  assign ce    = qadd(rt_r, ct_r);
  assign jp    = 32'(prod_r >> JP_SHIFT);
  assign cd    = qsub(qsub(d_r, jp), qadd(jp, jp));
  assign abs_d = in_data.move_distance[31] ? 32'(-in_data.move_distance)
                                           : 32'(in_data.move_distance);
  assign c3    = {32'd0, lo_r} + {prod_r, 32'd0};
  assign fits  = c3 <= (96'(x_r) << (2 * FRAC_BITS));
  assign rn    = fits ? cand : r_r;

  // Pick multiplier operands
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (st_r)
      S_VT:  begin mul_a = v_r;          mul_b = t_r; end
      S_VT2: begin mul_a = d_r;          mul_b = d_r; end
      S_DD2: begin mul_a = jerk_r;       mul_b = qm; end
      S_C1:  begin mul_a = cand;         mul_b = cand; end
      S_C2:  begin mul_a = prod_r[31:0]; mul_b = cand; end
      S_C3:  begin mul_a = c2hi_r;       mul_b = cand; end
      S_J1:  begin mul_a = jerk_r;       mul_b = x_r; end
      S_J2:  begin mul_a = qm;           mul_b = x_r; end
      S_J3:  begin mul_a = qm;           mul_b = x_r; end
      S_J4:  begin mul_a = qm;           mul_b = JP_RECIP; end
      S_SMP: begin mul_a = vc_r;         mul_b = s_r - rt_r; end
      S_P2:  begin mul_a = vc_r;         mul_b = x_r; end
      default: begin mul_a = 32'd0;      mul_b = 32'd0; end
    endcase
  end

  // Launch divisions and square roots
  always_comb begin
    div_start = 1'b0;
    div_num   = 64'd0;
    div_den   = jerk_r;
    sq_start  = 1'b0;
    sq_n      = 64'(div_quo) << FRAC_BITS;
    case (st_r)
      S_CAP: begin
        div_start = 1'b1;
        div_num   = 64'(accel_r) << FRAC_BITS;
      end
      S_CAPW: begin
        div_start = div_done;
        div_num   = 64'(v_r) << (FRAC_BITS + 1);
      end
      S_RTW: sq_start = div_done;
      S_J5: begin
        div_start = (ctx_r == CTX_PLAN) && (vc_r != 32'd0);
        div_num   = 64'(cd) << FRAC_BITS;
        div_den   = vc_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jerk_r  <= JERK_RST;
      accel_r <= ACCEL_RST;
      vlim_r  <= VLIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_JERK:  jerk_r  <= cfg_wdata;
        CFG_ACCEL: accel_r <= cfg_wdata;
        CFG_VLIM:  vlim_r  <= cfg_wdata;
        default:   jerk_r  <= jerk_r;
      endcase
    end
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r              <= 1'b1;
      out_data_r.velocity      <= ovel_r;
      out_data_r.position      <= opos_r;
      out_data_r.phase         <= oph_r;
      out_data_r.total_time    <= dur_r;
      out_data_r.peak_velocity <= vc_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      len_r       <= 32'd0;
      vc_r        <= 32'd0;
      rt_r        <= 32'd0;
      rd_r        <= 32'd0;
      cd_r        <= 32'd0;
      ct_r        <= 32'd0;
      dur_r       <= 32'd0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            ovel_r <= 32'd0;
            opos_r <= 32'd0;
            oph_r  <= PH_ACCEL;
            if (in_data.req_type == REQ_PLAN) begin
              d_r    <= abs_d;
              v_r    <= (in_data.target_velocity > vlim_r ||
                         in_data.target_velocity == 32'd0) ? vlim_r
                                                          : in_data.target_velocity;
              pass_r <= 1'b0;
              st_r   <= S_CAP;
            end else begin
              s_r  <= in_data.sample_time;
              st_r <= S_SMP;
            end
          end
        end
        S_CAP: st_r <= S_CAPW;
        S_CAPW: begin
          if (div_done) begin
            cap_r <= div_quo;
            st_r  <= S_RTW;
          end
        end
        S_RTW: if (div_done) st_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (!pass_r) begin
              t_r  <= t_min;
              st_r <= S_VT;
            end else begin
              rt_r  <= t_min;
              x_r   <= t_min;
              ctx_r <= CTX_PLAN;
              st_r  <= S_J1;
            end
          end
        end
        S_VT: st_r <= S_VT2;
        // Short move: reduce the peak by a cube root
        S_VT2: begin
          if (d_r < qm) begin
            st_r <= S_DD2;
          end else begin
            vc_r   <= v_r;
            pass_r <= 1'b1;
            st_r   <= S_CAP;
          end
        end
        S_DD2: st_r <= S_W;
        S_W: begin
          x_r  <= sat32(prod_r >> (FRAC_BITS + 1));
          r_r  <= 32'd0;
          b_r  <= 5'd31;
          st_r <= S_C1;
        end
        S_C1: st_r <= S_C2;
        S_C2: begin
          c2hi_r <= prod_r[63:32];
          st_r   <= S_C3;
        end
        S_C3: begin
          lo_r <= prod_r;
          st_r <= S_C4;
        end
        S_C4: begin
          if (b_r == 5'd0) begin
            vc_r   <= rn;
            v_r    <= rn;
            pass_r <= 1'b1;
            st_r   <= S_CAP;
          end else begin
            r_r  <= rn;
            b_r  <= b_r - 5'd1;
            st_r <= S_C1;
          end
        end
        // Jerk terms of x_r: q2 for velocity, q3 / 6 for position
        S_J1: st_r <= S_J2;
        S_J2: st_r <= S_J3;
        S_J3: begin
          q2_r <= qm;
          st_r <= S_J4;
        end
        S_J4: st_r <= S_J5;
        S_J5: begin
          case (ctx_r)
            CTX_PLAN: begin
              rd_r <= jp;
              cd_r <= cd;
              if (vc_r != 32'd0) begin
                st_r <= S_CT;
              end else begin
                ct_r <= 32'd0;
                st_r <= S_DUR;
              end
            end
            CTX_PH0: begin
              ovel_r <= q2_r >> 1;
              opos_r <= jp;
              oph_r  <= PH_ACCEL;
              st_r   <= S_OUT;
            end
            default: begin
              jp_r   <= jp;
              ovel_r <= qsub(vc_r, q2_r >> 1);
              st_r   <= S_P2;
            end
          endcase
        end
        S_CT: begin
          if (div_done) begin
            ct_r <= div_quo;
            st_r <= S_DUR;
          end
        end
        S_DUR: begin
          dur_r <= qadd(qadd(rt_r, ct_r), rt_r);
          len_r <= d_r;
          st_r  <= S_OUT;
        end
        // Pick the phase of a sample
        S_SMP: begin
          if (s_r >= dur_r) begin
            opos_r <= len_r;
            oph_r  <= PH_DONE;
            st_r   <= S_OUT;
          end else if (s_r < rt_r) begin
            x_r   <= s_r;
            ctx_r <= CTX_PH0;
            st_r  <= S_J1;
          end else if (s_r < ce) begin
            ovel_r <= vc_r;
            oph_r  <= PH_CRUISE;
            st_r   <= S_P1;
          end else begin
            x_r   <= s_r - ce;
            ctx_r <= CTX_PH2;
            oph_r <= PH_DECEL;
            st_r  <= S_J1;
          end
        end
        S_P1: begin
          opos_r <= qadd(rd_r, qm);
          st_r   <= S_OUT;
        end
        S_P2: st_r <= S_P2B;
        S_P2B: begin
          opos_r <= qsub(qadd(qadd(rd_r, cd_r), qm), jp_r);
          st_r   <= S_OUT;
        end
        // Hand the word to the output register
        S_OUT: begin
          if (out_free) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the S-curve motion profile unit: queued driver, monitor, predictor.
`timescale 1ns / 100ps

module testbench;
  import scmp_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int RAND_ITEMS = 950;
  localparam int DRAIN_CYCLES = 1200;

  // Register index past the last register; writes to it are ignored
  localparam logic [1:0] CFG_NONE = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  scurve_motion_profile_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Profile limits and stored profile of the predictor
  logic [31:0] lim_jerk, lim_accel, lim_vel;
  logic [31:0] prof_len, prof_peak, prof_ramp_t, prof_ramp_d;
  logic [31:0] prof_cruise_d, prof_cruise_t, prof_total;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        errors;
  int        sent_total;
  bit        idle_on;
  bit        hold_long;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Fixed-point arithmetic of the profile
  function automatic logic [31:0] clip32(input logic [127:0] x);
    return (x > 128'hFFFF_FFFF) ? QMAX : x[31:0];
  endfunction

  function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return clip32(p >> F);
  endfunction

  function automatic logic [31:0] wide_div(input logic [63:0] num, input logic [31:0] den);
    if (den == 0) return QMAX;
    return clip32(num / den);
  endfunction

  function automatic logic [31:0] fx_div(input logic [31:0] a, input logic [31:0] b);
    return wide_div({32'd0, a} << F, b);
  endfunction

  function automatic logic [31:0] fx_sqrt(input logic [31:0] x);
    logic [63:0] n;
    logic [63:0] r;
    n = {32'd0, x} << F;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r = r | (64'd1 << b);
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] fx_cbrt(input logic [31:0] x);
    logic [127:0] lim;
    logic [127:0] c;
    logic [31:0]  r;
    lim = {96'd0, x} << (2 * F);
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = {96'd0, r | (32'd1 << b)};
      if (c * c * c <= lim) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [31:0] ramp_vel(input logic [31:0] t);
    return fx_mul(fx_mul(lim_jerk, t), t) / 2;
  endfunction

  function automatic logic [31:0] ramp_pos(input logic [31:0] t);
    return fx_mul(fx_mul(fx_mul(lim_jerk, t), t), t) / 6;
  endfunction

  function automatic logic [31:0] ramp_time_for(input logic [31:0] v);
    logic [31:0] cap;
    logic [31:0] rt;
    cap = fx_div(lim_accel, lim_jerk);
    rt = fx_sqrt(wide_div({32'd0, v} << (F + 1), lim_jerk));
    return (cap < rt) ? cap : rt;
  endfunction

  // Plan a move or sample the stored profile, and queue the expected word
  task automatic predict_profile(input in_word_t w);
    out_word_t   o;
    logic [31:0] d, v, vc, s, cend, u, p;
    logic [95:0] sq;
    o = '0;
    if (w.req_type == REQ_PLAN) begin
      d = w.move_distance[31] ? (~w.move_distance + 32'd1) : w.move_distance;
      v = w.target_velocity;
      if (v > lim_vel || v == 0) v = lim_vel;
      if (d < fx_mul(v, ramp_time_for(v))) begin
        sq = {64'd0, lim_jerk} * {64'd0, fx_mul(d, d)};
        vc = fx_cbrt(clip32({32'd0, sq} >> (F + 1)));
      end else begin
        vc = v;
      end
      prof_len = d;
      prof_peak = vc;
      prof_ramp_t = ramp_time_for(vc);
      prof_ramp_d = ramp_pos(prof_ramp_t);
      prof_cruise_d = qsub(qsub(d, prof_ramp_d), qadd(prof_ramp_d, prof_ramp_d));
      prof_cruise_t = (vc != 0) ? fx_div(prof_cruise_d, vc) : 32'd0;
      prof_total = qadd(qadd(prof_ramp_t, prof_cruise_t), prof_ramp_t);
    end else begin
      s = w.sample_time;
      cend = qadd(prof_ramp_t, prof_cruise_t);
      if (s >= prof_total) begin
        o.position = prof_len;
        o.phase = PH_DONE;
      end else if (s < prof_ramp_t) begin
        o.velocity = ramp_vel(s);
        o.position = ramp_pos(s);
        o.phase = PH_ACCEL;
      end else if (s < cend) begin
        o.velocity = prof_peak;
        o.position = qadd(prof_ramp_d, fx_mul(prof_peak, s - prof_ramp_t));
        o.phase = PH_CRUISE;
      end else begin
        u = s - cend;
        o.velocity = qsub(prof_peak, ramp_vel(u));
        p = qadd(qadd(prof_ramp_d, prof_cruise_d), fx_mul(prof_peak, u));
        o.position = qsub(p, ramp_pos(u));
        o.phase = PH_DECEL;
      end
    end
    o.total_time = prof_total;
    o.peak_velocity = prof_peak;
    expected_words.push_back(o);
  endtask

  // Driver: offer queued words, drop each one once accepted, predict at acceptance
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_profile(in_data);
        void'(pending_words.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!(in_valid && in_stall) && idle_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation
  int out_gap;
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_data.velocity !== e.velocity) begin
            $error("velocity exp %h got %h", e.velocity, out_data.velocity); errors++;
          end
          if (out_data.position !== e.position) begin
            $error("position exp %h got %h", e.position, out_data.position); errors++;
          end
          if (out_data.phase !== e.phase) begin
            $error("phase exp %0d got %0d", e.phase, out_data.phase); errors++;
          end
          if (out_data.total_time !== e.total_time) begin
            $error("total_time exp %h got %h", e.total_time, out_data.total_time); errors++;
          end
          if (out_data.peak_velocity !== e.peak_velocity) begin
            $error("peak_velocity exp %h got %h", e.peak_velocity, out_data.peak_velocity);
            errors++;
          end
        end
      end
      if (hold_long) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process, started while words are queued
  initial begin
    hold_long = 1'b0;
    wait (sent_total > 300 && pending_words.size() > 2);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_long <= 1'b0;
  end

  task automatic send_word(input logic rt, input logic [31:0] d, input logic [31:0] v,
                           input logic [31:0] s);
    in_word_t w;
    w.req_type = rt;
    w.move_distance = d;
    w.target_velocity = v;
    w.sample_time = s;
    pending_words.push_back(w);
    sent_total++;
  endtask

  // Wait until all words are through and the block is idle
  task automatic drain_all();
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and drop the write enable, then update the predictor's limits
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_JERK:  lim_jerk = val;
      CFG_ACCEL: lim_accel = val;
      CFG_VLIM:  lim_vel = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_distance();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 32'h0040_0000);
      2: return -$urandom_range(0, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    logic [31:0] lo;
    lo = prof_total;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, prof_ramp_t);
      2: return qadd(prof_ramp_t, $urandom_range(0, prof_cruise_t));
      3: return qadd(qadd(prof_ramp_t, prof_cruise_t), $urandom_range(0, prof_ramp_t));
      4: return qadd(lo, $urandom_range(0, 3));
      default: return $urandom_range(0, lo);
    endcase
  endfunction

  // One random phase: a plan then a run of samples across its profile
  task automatic random_moves(input int n);
    int k;
    k = 0;
    while (k < n) begin
      send_word(REQ_PLAN, rand_distance(),
                ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, $urandom);
      k++;
      wait (pending_words.size() == 0);
      wait (expected_words.size() == 0);
      for (int i = $urandom_range(3, 12); i > 0; i--) begin
        send_word(REQ_SAMPLE, $urandom, $urandom, rand_time());
        k++;
      end
    end
  endtask

  initial begin
    sent_total = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_JERK;
    cfg_wdata = '0;
    lim_jerk = JERK_RST;
    lim_accel = ACCEL_RST;
    lim_vel = VLIM_RST;
    {prof_len, prof_peak, prof_ramp_t, prof_ramp_d} = '0;
    {prof_cruise_d, prof_cruise_t, prof_total} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sample before any plan, distance extremes, velocity extremes
    send_word(REQ_SAMPLE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_word(REQ_PLAN, 32'd0, 32'd0, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'd0);
    send_word(REQ_PLAN, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'h0000_1000);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'h0002_0000);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_word(REQ_PLAN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'h0010_0000);
    send_word(REQ_PLAN, 32'hFFFF_0000, 32'h0001_0000, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'h0000_4000);
    send_word(REQ_PLAN, 32'd1, 32'd1, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'd1);
    drain_all();

    // Zero jerk: every division by it saturates
    write_reg(CFG_JERK, 32'd0);
    write_reg(CFG_NONE, 32'd5);
    send_word(REQ_PLAN, 32'h0010_0000, 32'd0, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'h0000_8000);
    send_word(REQ_PLAN, 32'd3, 32'd0, 32'd0);
    send_word(REQ_SAMPLE, 32'd0, 32'd0, 32'd0);
    drain_all();

    // Random phases under several limit settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_JERK, JERK_RST); write_reg(CFG_ACCEL, ACCEL_RST);
                 write_reg(CFG_VLIM, VLIM_RST); end
        1: begin write_reg(CFG_JERK, 32'hFFFF_FFFF); write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
                 write_reg(CFG_VLIM, 32'hFFFF_FFFF); end
        2: begin write_reg(CFG_JERK, 32'd1); write_reg(CFG_ACCEL, 32'd1);
                 write_reg(CFG_VLIM, 32'd1); end
        3: begin write_reg(CFG_JERK, $urandom); write_reg(CFG_ACCEL, $urandom);
                 write_reg(CFG_VLIM, $urandom); end
        4: begin write_reg(CFG_JERK, 32'h0001_0000); write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
                 write_reg(CFG_VLIM, $urandom_range(1, 32'h0100_0000)); end
        default: begin idle_on = 1'b0; write_reg(CFG_JERK, JERK_RST);
                 write_reg(CFG_ACCEL, ACCEL_RST); write_reg(CFG_VLIM, VLIM_RST); end
      endcase
      random_moves(RAND_ITEMS / 6);
      drain_all();
    end

    if (errors == 0) begin
      $display("scurve_motion_profile_unit verification clean");
    end else begin
      $display("scurve_motion_profile_unit verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("scurve_motion_profile_unit verification failed");
    $finish;
  end

endmodule

### scurve_motion_profile_unit.f
hw/rtl/scmp_pkg.sv
hw/rtl/scmp_div.sv
hw/rtl/scmp_sqrt.sv
hw/rtl/scurve_motion_profile_unit.sv
tb/testbench.sv
